@@ hw/rtl/dsync_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsync_pkg: shared types and constants
// Widths, codes and structs used by the straight-drive sync block.
// ----------------------------------------------------------------------------
package dsync_pkg;

   localparam int TARGET_W   = 23;
   localparam int SPEED_W    = 11;
   localparam int STEP_W     = 12;
   localparam int FACTOR_W   = 17;
   localparam int DRIVE_W    = 12;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 23;
   localparam int RSP_DATA_W = 32;

   // 1.0 in Q16
   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

   typedef enum logic [MODE_W-1:0] {
      MODE_DRIVE = 2'd0,
      MODE_HOLD  = 2'd1,
      MODE_OFF   = 2'd2
   } mode_type;

   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET  = 2'd0,
      CSR_SPEED   = 2'd1,
      CSR_STEP    = 2'd2,
      CSR_REVERSE = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_ticks;
      logic [SPEED_W-1:0]  base_speed;
      logic [STEP_W-1:0]   step_size;
      logic                reverse_mode;
   } cfg_type;

   // packed from run_done down to left_drive, so left_drive sits in the low bits
   typedef struct packed {
      logic                      run_done;
      mode_type                  right_mode;
      mode_type                  left_mode;
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
   } rsp_type;

endpackage

@@ hw/rtl/dsync_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsync_cfg: configuration registers
// Holds target, speed, step and direction written through the csr port.
// ----------------------------------------------------------------------------
module dsync_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dsync_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dsync_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dsync_pkg::cfg_type                  cfg
);

   dsync_pkg::cfg_type cfg_ff;
   dsync_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (dsync_pkg::csr_addr_type'(csr_addr))
            dsync_pkg::CSR_TARGET: begin
               cfg_in.target_ticks = csr_wdata[dsync_pkg::TARGET_W-1:0];
            end
            dsync_pkg::CSR_SPEED: begin
               cfg_in.base_speed = csr_wdata[dsync_pkg::SPEED_W-1:0];
            end
            dsync_pkg::CSR_STEP: begin
               cfg_in.step_size = csr_wdata[dsync_pkg::STEP_W-1:0];
            end
            dsync_pkg::CSR_REVERSE: begin
               cfg_in.reverse_mode = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/dsync_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsync_step: per-request correction logic
// Compares the wheel counts, steps the power factors and scales the drive.
// ----------------------------------------------------------------------------
module dsync_step #(
   parameter int COUNT_BITS = 24
) (
   input  dsync_pkg::cfg_type                    cfg,
   input  logic                                  cmd,
   input  logic signed [COUNT_BITS-1:0]          left_count,
   input  logic signed [COUNT_BITS-1:0]          right_count,
   input  logic [dsync_pkg::FACTOR_W-1:0]        left_factor,
   input  logic [dsync_pkg::FACTOR_W-1:0]        right_factor,
   input  logic                                  finished,
   output logic [dsync_pkg::FACTOR_W-1:0]        left_factor_nxt,
   output logic [dsync_pkg::FACTOR_W-1:0]        right_factor_nxt,
   output logic                                  finished_nxt,
   output dsync_pkg::rsp_type                    rsp
);

   localparam int MagW  = COUNT_BITS + 1;
   localparam int CmpW  = (MagW > dsync_pkg::TARGET_W) ? MagW : dsync_pkg::TARGET_W;
   localparam int ProdW = dsync_pkg::FACTOR_W + dsync_pkg::SPEED_W;

   logic [MagW-1:0] left_ext;
   logic [MagW-1:0] right_ext;
   logic [MagW-1:0] left_mag;
   logic [MagW-1:0] right_mag;
   logic            hit;
   logic [dsync_pkg::FACTOR_W-1:0] left_low;
   logic [dsync_pkg::FACTOR_W-1:0] right_low;

   function automatic logic [dsync_pkg::FACTOR_W-1:0] lower_factor(
      input logic [dsync_pkg::FACTOR_W-1:0] f,
      input logic [dsync_pkg::STEP_W-1:0]   s
   );
      logic [dsync_pkg::FACTOR_W-1:0] sx;
      sx = dsync_pkg::FACTOR_W'(s);
      return (f > sx) ? (f - sx) : '0;
   endfunction

   function automatic logic [dsync_pkg::DRIVE_W-1:0] drive_of(
      input logic [dsync_pkg::FACTOR_W-1:0] f,
      input logic [dsync_pkg::SPEED_W-1:0]  speed,
      input logic                           rev
   );
      logic [ProdW-1:0]              prod;
      logic [dsync_pkg::DRIVE_W-1:0] mag;
      prod = ProdW'(f) * ProdW'(speed);
      mag  = prod[16 +: dsync_pkg::DRIVE_W];
      return rev ? (dsync_pkg::DRIVE_W'(0) - mag) : mag;
   endfunction

   // magnitudes one bit wider so the most negative count stays exact
   assign left_ext  = {left_count[COUNT_BITS-1], left_count};
   assign right_ext = {right_count[COUNT_BITS-1], right_count};
   assign left_mag  = left_ext[MagW-1]  ? (MagW'(0) - left_ext)  : left_ext;
   assign right_mag = right_ext[MagW-1] ? (MagW'(0) - right_ext) : right_ext;

   assign hit = (CmpW'(left_mag)  >= CmpW'(cfg.target_ticks)) ||
                (CmpW'(right_mag) >= CmpW'(cfg.target_ticks));

   assign left_low  = lower_factor(left_factor, cfg.step_size);
   assign right_low = lower_factor(right_factor, cfg.step_size);

   always_comb begin
      left_factor_nxt  = left_factor;
      right_factor_nxt = right_factor;
      finished_nxt     = finished;
      rsp.left_drive   = '0;
      rsp.right_drive  = '0;
      rsp.left_mode    = dsync_pkg::MODE_OFF;
      rsp.right_mode   = dsync_pkg::MODE_OFF;
      rsp.run_done     = 1'b0;
      if (cmd == dsync_pkg::CMD_START) begin
         left_factor_nxt  = dsync_pkg::FACTOR_ONE;
         right_factor_nxt = dsync_pkg::FACTOR_ONE;
         finished_nxt     = 1'b0;
      end else if (finished) begin
         rsp.run_done = 1'b1;
      end else if (hit) begin
         finished_nxt = 1'b1;
         rsp.run_done = 1'b1;
      end else begin
         if (left_count == right_count) begin
            left_factor_nxt  = dsync_pkg::FACTOR_ONE;
            right_factor_nxt = dsync_pkg::FACTOR_ONE;
         end else if (cfg.reverse_mode) begin
            // equal magnitudes of opposite sign leave both factors alone
            if (left_mag > right_mag) begin
               right_factor_nxt = dsync_pkg::FACTOR_ONE;
               left_factor_nxt  = left_low;
            end else if (right_mag > left_mag) begin
               left_factor_nxt  = dsync_pkg::FACTOR_ONE;
               right_factor_nxt = right_low;
            end
         end else if (left_count > right_count) begin
            right_factor_nxt = dsync_pkg::FACTOR_ONE;
            left_factor_nxt  = left_low;
         end else begin
            left_factor_nxt  = dsync_pkg::FACTOR_ONE;
            right_factor_nxt = right_low;
         end
         rsp.left_drive  = drive_of(left_factor_nxt, cfg.base_speed, cfg.reverse_mode);
         rsp.right_drive = drive_of(right_factor_nxt, cfg.base_speed, cfg.reverse_mode);
         rsp.left_mode   = dsync_pkg::MODE_DRIVE;
         rsp.right_mode  = dsync_pkg::MODE_DRIVE;
      end
   end

endmodule

@@ hw/rtl/two_wheel_drive_straight_sync_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wheel_drive_straight_sync_top: wheel sync correction for straight runs
// Balances two wheel power factors from encoder samples and issues drives.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request per command. req_tuser is the command (start a
//   new run or control sample); req_tdata carries both signed encoder counts.
//   rsp channel: exactly one response per request, in order, with both wheel
//   drives, both wheel modes and the run-done flag.
//   csr port: write target, speed, step and direction while the block is idle.
// Timing:
//   A request waits in the input register, the correction logic runs
//   between that register and the response register, and the response
//   is registered there until it is taken. One request can be accepted
//   every cycle while rsp_tready stays high; the factor feedback closes
//   within that single stage.
// Reset:
//   Synchronous, active high: both factors return to 1.0, the done flag and
//   all valid flags clear, and the configuration registers read zero.
// Backpressure:
//   When rsp_tready is low the response holds; the input register still
//   takes one more request, and req_tready drops only when both are full.
// ----------------------------------------------------------------------------
module two_wheel_drive_straight_sync_top #(
   parameter  int COUNT_BITS = 24,
   localparam int ReqDataW   = ((2 * COUNT_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // fields from bit 0: left_count, right_count, zero pad
   input  logic [ReqDataW-1:0]                  req_tdata,
   // fields from bit 0: command
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // fields from bit 0: left_drive, right_drive, left_mode, right_mode,
   // run_done, zero pad
   output logic [dsync_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [dsync_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [dsync_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RspW = $bits(dsync_pkg::rsp_type);

   dsync_pkg::cfg_type cfg;

   // input register
   logic                          s1_valid_ff;
   logic                          s1_cmd_ff;
   logic signed [COUNT_BITS-1:0]  s1_left_ff;
   logic signed [COUNT_BITS-1:0]  s1_right_ff;

   // run state
   logic [dsync_pkg::FACTOR_W-1:0] left_factor_ff;
   logic [dsync_pkg::FACTOR_W-1:0] right_factor_ff;
   logic                           finished_ff;
   logic [dsync_pkg::FACTOR_W-1:0] left_factor_in;
   logic [dsync_pkg::FACTOR_W-1:0] right_factor_in;
   logic                           finished_in;

   // response register
   logic                rsp_valid_ff;
   dsync_pkg::rsp_type  rsp_ff;
   dsync_pkg::rsp_type  rsp_in;

   logic out_free;
   logic s1_go;
   logic req_take;

   dsync_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dsync_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .cfg              (cfg),
      .cmd              (s1_cmd_ff),
      .left_count       (s1_left_ff),
      .right_count      (s1_right_ff),
      .left_factor      (left_factor_ff),
      .right_factor     (right_factor_ff),
      .finished         (finished_ff),
      .left_factor_nxt  (left_factor_in),
      .right_factor_nxt (right_factor_in),
      .finished_nxt     (finished_in),
      .rsp              (rsp_in)
   );

   // advance the input stage whenever the response register is empty or drains
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         left_factor_ff  <= dsync_pkg::FACTOR_ONE;
         right_factor_ff <= dsync_pkg::FACTOR_ONE;
         finished_ff     <= 1'b0;
      end else begin
         // hold the stage while blocked, drop it once passed on
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff    <= 1'b1;
            left_factor_ff  <= left_factor_in;
            right_factor_ff <= right_factor_in;
            finished_ff     <= finished_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= req_tuser;
         s1_left_ff  <= req_tdata[COUNT_BITS-1:0];
         s1_right_ff <= req_tdata[2*COUNT_BITS-1:COUNT_BITS];
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dsync_pkg::RSP_DATA_W - RspW){1'b0}}, rsp_ff};

   // a start request restores both factors and reopens the run
   a_start_restores: assert property (@(posedge clock) disable iff (reset)
      s1_go && (s1_cmd_ff == dsync_pkg::CMD_START) |=>
         (left_factor_ff == dsync_pkg::FACTOR_ONE) &&
         (right_factor_ff == dsync_pkg::FACTOR_ONE) && !finished_ff)
      else $error("start did not restore run state");

   // once finished, only a start request reopens the run
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff && !(s1_go && (s1_cmd_ff == dsync_pkg::CMD_START)) |=> finished_ff)
      else $error("finished flag cleared without start");

   // a finished response drives nothing
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.run_done |->
         (rsp_ff.left_drive == '0) && (rsp_ff.right_drive == '0) &&
         (rsp_ff.left_mode == dsync_pkg::MODE_OFF) &&
         (rsp_ff.right_mode == dsync_pkg::MODE_OFF))
      else $error("done response with active drive");

   // factors never exceed 1.0
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      (left_factor_ff <= dsync_pkg::FACTOR_ONE) &&
      (right_factor_ff <= dsync_pkg::FACTOR_ONE))
      else $error("power factor above one");

endmodule

@@ test/tb_two_wheel_drive_straight_sync_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_wheel_drive_straight_sync_top: self-checking bench for wheel sync
// Drives start and sample requests with random pacing on both channels. An
// in-bench model of the factor trimming predicts every response, and the
// checker compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_two_wheel_drive_straight_sync_top;
   import dsync_pkg::*;

   localparam int COUNT_W     = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 1250;
   localparam int SHOWN_MAX   = 10;

   localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MIN  = {1'b1, {(COUNT_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = {1'b0, {(COUNT_W-1){1'b1}}};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // fields from bit 0: left_count, right_count
   logic [2*COUNT_W-1:0]    req_tdata;
   // fields from bit 0: command
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // fields from bit 0: left_drive, right_drive, left_mode, right_mode,
   // run_done, zero pad
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // Model copy of the block: registers, both wheel gains and the done flag.
   cfg_type               drive_cfg   = '0;
   logic [FACTOR_W-1:0]   left_gain   = FACTOR_ONE;
   logic [FACTOR_W-1:0]   right_gain  = FACTOR_ONE;
   logic                  run_over    = 1'b0;

   // Responses predicted at request acceptance, oldest first.
   rsp_type               pending_drives[$];

   int                    requests_sent    = 0;
   int                    drive_mismatches = 0;
   int unsigned           cycle_count      = 0;
   int                    send_gap_max     = 13;
   int                    recv_gap_max     = 13;

   two_wheel_drive_straight_sync_top #(
      .COUNT_BITS (COUNT_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run; the limit covers every request waiting out both
   // the longest sender gap and the longest receiver stall many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Lower a gain by one step, saturating at zero.
   function automatic logic [FACTOR_W-1:0] trim_gain(logic [FACTOR_W-1:0] g);
      return (g > drive_cfg.step_size) ? g - drive_cfg.step_size : '0;
   endfunction

   // Drive is gain times speed in Q16, truncated, negated for backward travel.
   function automatic logic signed [DRIVE_W-1:0] drive_for(logic [FACTOR_W-1:0] g);
      logic [FACTOR_W+SPEED_W-1:0] prod;
      logic [DRIVE_W-1:0]          mag;
      prod = g * drive_cfg.base_speed;
      mag  = prod[FACTOR_W+SPEED_W-1:16];
      return drive_cfg.reverse_mode ? -mag : mag;
   endfunction

   function automatic rsp_type predict_wheels(cmd_type cmd,
                                              logic signed [COUNT_W-1:0] lc,
                                              logic signed [COUNT_W-1:0] rc);
      rsp_type res;
      int      lmag;
      int      rmag;
      res            = '0;
      res.left_mode  = MODE_OFF;
      res.right_mode = MODE_OFF;
      if (cmd == CMD_START) begin
         left_gain  = FACTOR_ONE;
         right_gain = FACTOR_ONE;
         run_over   = 1'b0;
         return res;
      end
      if (run_over) begin
         res.run_done = 1'b1;
         return res;
      end
      lmag = (lc < 0) ? -int'(lc) : int'(lc);
      rmag = (rc < 0) ? -int'(rc) : int'(rc);
      // Either wheel at the target ends the run; both go off, gains kept.
      if (lmag >= int'(drive_cfg.target_ticks) || rmag >= int'(drive_cfg.target_ticks)) begin
         run_over     = 1'b1;
         res.run_done = 1'b1;
         return res;
      end
      if (lc == rc) begin
         left_gain  = FACTOR_ONE;
         right_gain = FACTOR_ONE;
      end else if (drive_cfg.reverse_mode) begin
         // Backward: compare magnitudes; equal magnitudes leave both gains.
         if (lmag > rmag) begin
            right_gain = FACTOR_ONE;
            left_gain  = trim_gain(left_gain);
         end else if (rmag > lmag) begin
            left_gain  = FACTOR_ONE;
            right_gain = trim_gain(right_gain);
         end
      end else if (lc > rc) begin
         right_gain = FACTOR_ONE;
         left_gain  = trim_gain(left_gain);
      end else begin
         left_gain  = FACTOR_ONE;
         right_gain = trim_gain(right_gain);
      end
      res.left_drive  = drive_for(left_gain);
      res.right_drive = drive_for(right_gain);
      res.left_mode   = MODE_DRIVE;
      res.right_mode  = MODE_DRIVE;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stalls and the checker
   // ------------------------------------------------------------------------

   // Stall a random number of cycles before taking each response.
   initial begin : rsp_pacer
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = $urandom_range(0, recv_gap_max);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : rsp_checker
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (pending_drives.size() == 0) begin
            drive_mismatches++;
            if (drive_mismatches <= SHOWN_MAX)
               $display("%0t: response with none expected:", $realtime,
                        " ld=%0d rd=%0d lm=%0d rm=%0d done=%0d",
                        got.left_drive, got.right_drive, got.left_mode,
                        got.right_mode, got.run_done);
         end else begin
            want = pending_drives.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                got.left_mode !== want.left_mode || got.right_mode !== want.right_mode ||
                got.run_done !== want.run_done) begin
               drive_mismatches++;
               if (drive_mismatches <= SHOWN_MAX)
                  $display("%0t: mismatch expected", $realtime,
                           " ld=%0d rd=%0d lm=%0d rm=%0d done=%0d,",
                           want.left_drive, want.right_drive, want.left_mode,
                           want.right_mode, want.run_done,
                           " got ld=%0d rd=%0d lm=%0d rm=%0d done=%0d",
                           got.left_drive, got.right_drive,
                           got.left_mode, got.right_mode, got.run_done);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one request after a random gap; predict its response on acceptance.
   // Valid stays high on return so back-to-back requests need no toggle.
   task automatic send_wheel_request(cmd_type cmd, logic [COUNT_W-1:0] lc,
                                     logic [COUNT_W-1:0] rc);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         // drop valid and scramble the bus while idle
         req_tvalid <= 1'b0;
         req_tdata  <= (2*COUNT_W)'({$urandom, $urandom});
         req_tuser  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rc, lc};
      do @(posedge clock); while (!req_tready);
      pending_drives.push_back(predict_wheels(cmd, lc, rc));
      requests_sent++;
   endtask

   // Hold off new requests until every predicted response has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
   endtask

   // Write all four registers back to back while the block is idle.
   task automatic load_settings(logic [TARGET_W-1:0] target, logic [SPEED_W-1:0] speed,
                                logic [STEP_W-1:0] step, logic reverse);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TARGET;
      csr_wdata <= CSR_DATA_W'(target);
      @(posedge clock);
      csr_addr  <= CSR_SPEED;
      csr_wdata <= CSR_DATA_W'(speed);
      @(posedge clock);
      csr_addr  <= CSR_STEP;
      csr_wdata <= CSR_DATA_W'(step);
      @(posedge clock);
      csr_addr  <= CSR_REVERSE;
      csr_wdata <= CSR_DATA_W'(reverse);
      @(posedge clock);
      csr_we    <= 1'b0;
      drive_cfg.target_ticks = target;
      drive_cfg.base_speed   = speed;
      drive_cfg.step_size    = step;
      drive_cfg.reverse_mode = reverse;
   endtask

   function automatic int idle_span();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         default: return 13;
      endcase
   endfunction

   // One realistic run: start, then counts creeping toward the target with
   // one wheel now and then pulling ahead, plus a few samples past the end.
   task automatic run_straight();
      int lpos;
      int rpos;
      int dir;
      int tail;
      int n;
      dir  = drive_cfg.reverse_mode ? -1 : 1;
      lpos = 0;
      rpos = 0;
      tail = $urandom_range(0, 2);
      send_wheel_request(CMD_START, COUNT_W'($urandom), COUNT_W'($urandom));
      for (n = 0; n < 80; n++) begin
         case ($urandom_range(0, 9))
            0: rpos = lpos;
            1: rpos = -lpos;
            2: lpos += dir * int'($urandom_range(0, 3));
            default: begin
               lpos += dir * int'($urandom_range(0, 40));
               rpos += dir * int'($urandom_range(0, 40));
            end
         endcase
         send_wheel_request(CMD_SAMPLE, COUNT_W'(lpos), COUNT_W'(rpos));
         if (run_over) begin
            if (tail == 0) break;
            tail--;
         end
         // now and then let the pipeline run dry mid-run
         if ($urandom_range(0, 99) == 0) wait_for_results();
      end
   endtask

   // Arbitrary request: full-range counts, extremes and stray starts.
   task automatic send_noise();
      logic [COUNT_W-1:0] lc;
      logic [COUNT_W-1:0] rc;
      lc = COUNT_W'($urandom);
      rc = COUNT_W'($urandom);
      case ($urandom_range(0, 5))
         0:       lc = COUNT_MIN;
         1:       rc = COUNT_MAX;
         2:       rc = lc;
         default: ;
      endcase
      send_wheel_request(($urandom_range(0, 7) == 0) ? CMD_START : CMD_SAMPLE, lc, rc);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Registers read zero after reset, so the first sample already ends the
   // run and the next one stays done.
   task automatic test_reset_defaults();
      send_wheel_request(CMD_SAMPLE, '0, '0);
      send_wheel_request(CMD_SAMPLE, COUNT_MAX, COUNT_MIN);
   endtask

   // Forward: even counts, left ahead long enough to drive its gain to zero,
   // right ahead, then a sample whose magnitude hits the far target.
   task automatic test_forward_trim();
      int i;
      load_settings(TARGET_MAX, SPEED_W'(1500), {STEP_W{1'b1}}, 1'b0);
      send_wheel_request(CMD_START, '0, '0);
      send_wheel_request(CMD_SAMPLE, COUNT_W'(5), COUNT_W'(5));
      for (i = 0; i < 17; i++)
         send_wheel_request(CMD_SAMPLE, COUNT_MAX - COUNT_W'(1 + i), COUNT_MIN + COUNT_W'(2 + i));
      send_wheel_request(CMD_SAMPLE, '0, COUNT_W'(1));
      send_wheel_request(CMD_SAMPLE, COUNT_MIN, COUNT_MAX);
   endtask

   // Backward: opposite signs of equal size keep the gains, otherwise the
   // larger magnitude is trimmed and drives come out negative.
   task automatic test_reverse_trim();
      load_settings(TARGET_W'(5000), SPEED_W'(1500), STEP_W'(700), 1'b1);
      send_wheel_request(CMD_START, '0, '0);
      send_wheel_request(CMD_SAMPLE, COUNT_W'(100), -COUNT_W'(100));
      send_wheel_request(CMD_SAMPLE, -COUNT_W'(200), COUNT_W'(100));
      send_wheel_request(CMD_SAMPLE, -COUNT_W'(100), -COUNT_W'(400));
   endtask

   // Random phases: new registers, new pacing, then mostly well-formed runs
   // with some noise. The first phase writes every register at its minimum.
   task automatic test_random_runs();
      int stop_at;
      int phase_end;
      int phase;
      logic [TARGET_W-1:0] target;
      logic [STEP_W-1:0]   step;
      stop_at = requests_sent + RANDOM_REQS;
      phase   = 0;
      while (requests_sent < stop_at) begin
         if (phase == 0) begin
            load_settings('0, '0, '0, 1'b0);
         end else begin
            case ($urandom_range(0, 7))
               0:       target = '0;
               1:       target = TARGET_MAX;
               2:       target = TARGET_W'($urandom);
               default: target = TARGET_W'($urandom_range(100, 1500));
            endcase
            case ($urandom_range(0, 4))
               0:       step = '0;
               1:       step = {STEP_W{1'b1}};
               2:       step = STEP_W'($urandom);
               default: step = STEP_W'($urandom_range(1, 600));
            endcase
            load_settings(target,
                          ($urandom_range(0, 3) == 0) ? SPEED_W'(0) :
                          ($urandom_range(0, 2) == 0) ? SPEED_W'(1500) :
                          SPEED_W'($urandom_range(0, 1500)),
                          step, 1'($urandom));
         end
         send_gap_max = idle_span();
         recv_gap_max = idle_span();
         phase_end    = requests_sent + 125;
         while (requests_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else run_straight();
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_START;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_TARGET;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_forward_trim();
      test_reverse_trim();
      test_random_runs();

      // drain, then give stray responses a few cycles to show up
      wait_for_results();
      repeat (8) @(posedge clock);
      if (drive_mismatches == 0 && pending_drives.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
